// ===== src/wrdh_pkg.sv =====
// ---------------------------------------------------------------------------
// wrdh_pkg: shared types and constants of the window rise detector
// Sample and register types, control bundles and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package wrdh_pkg;

   // payload widths fixed by the sensor and register formats
   localparam int SAMPLE_W    = 8;
   localparam int THRESH_W    = 8;
   localparam int DURATION_W  = 16;
   localparam int FILL_OUT_W  = 5;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   typedef logic [SAMPLE_W-1:0]    sample_type;
   typedef logic [THRESH_W-1:0]    thresh_type;
   typedef logic [DURATION_W-1:0]  duration_type;
   typedef logic [FILL_OUT_W-1:0]  fill_out_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   // register indexes
   localparam csr_index_type CSR_RISE_THRESHOLD = 8'd0;
   localparam csr_index_type CSR_MAX_DURATION   = 8'd1;

   // register reset values
   localparam thresh_type   THRESH_RESET   = 8'd0;
   localparam duration_type DURATION_RESET = 16'd16;

   // extreme sample values that seed the min/max scan
   localparam sample_type SAMPLE_MIN = 8'd0;
   localparam sample_type SAMPLE_MAX = 8'd255;

   // control of the sample chain
   typedef struct packed {
      logic step;    // every cell takes its neighbor's value
      logic insert;  // head cell takes the new sample instead of the tail
   } chain_ctl_type;

   // hold unit outcome for the current request
   typedef struct packed {
      logic         fan_on;
      duration_type hold_count;
   } hold_status_type;

endpackage

`default_nettype wire

// ===== src/wrdh_ifs.sv =====
// ---------------------------------------------------------------------------
// wrdh channel interfaces
// Valid/ready channels for requests, results and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface wrdh_req_if;
   logic                valid;
   logic                ready;
   wrdh_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface wrdh_rsp_if;
   logic                   valid;
   logic                   ready;
   logic                   fan_on;
   wrdh_pkg::duration_type hold_count;
   wrdh_pkg::sample_type   window_max;
   wrdh_pkg::sample_type   window_min;
   logic                   rising;
   wrdh_pkg::fill_out_type fill_level;

   modport source (output valid, output fan_on, output hold_count, output window_max,
                   output window_min, output rising, output fill_level, input ready);
   modport sink   (input valid, input fan_on, input hold_count, input window_max,
                   input window_min, input rising, input fill_level, output ready);
endinterface

interface wrdh_csr_if;
   logic                    valid;
   logic                    ready;
   wrdh_pkg::csr_index_type index;
   wrdh_pkg::csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/window_rise_detector_hold.sv =====
// No new request is taken until the previous one is committed; the min/max scan rotates
//    the cell chain once, one cell per cycle.
// A new request is taken while the previous result waits in the output register.
// Reset (synchronous): window empty, output off, hold count 0,
//    rise_threshold 0, max_duration 16. Window cells are not cleared.
// ---------------------------------------------------------------------------
// window_rise_detector_hold: sliding-window rise detector with output hold
// Keeps the newest samples in a row of cells, scans min/max, and holds the
// output on for a programmable number of samples after a trigger.
// ---------------------------------------------------------------------------
`default_nettype none

module window_rise_detector_hold #(
   parameter int WINDOW_DEPTH = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   wrdh_req_if.sink    req_chan,
   wrdh_rsp_if.source  rsp_chan,
   wrdh_csr_if.sink    csr_chan
);

   localparam int FillW = $clog2(WINDOW_DEPTH + 1);
   localparam int ScanW = $clog2(WINDOW_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]               state_ff;
   logic [1:0]               state_in;
   logic [FillW-1:0]         fill_ff;
   logic [FillW-1:0]         fill_in;
   logic [ScanW-1:0]         scan_ff;
   logic [ScanW-1:0]         scan_in;
   wrdh_pkg::sample_type     max_ff;
   wrdh_pkg::sample_type     max_in;
   wrdh_pkg::sample_type     min_ff;
   wrdh_pkg::sample_type     min_in;
   logic                     rise_ff;
   logic                     rise_in;
   wrdh_pkg::thresh_type     thresh_ff;
   wrdh_pkg::duration_type   dur_ff;
   logic                     rsp_valid_ff;
   logic                     out_fan_ff;
   wrdh_pkg::duration_type   out_hold_ff;
   wrdh_pkg::sample_type     out_max_ff;
   wrdh_pkg::sample_type     out_min_ff;
   logic                     out_rise_ff;
   wrdh_pkg::fill_out_type   out_fill_ff;

   logic                     req_fire;
   logic                     commit;
   logic                     in_window;
   logic [FillW:0]           scan_pos;
   logic [FillW+4:0]         fill_wide;
   wrdh_pkg::chain_ctl_type  chain_ctl;
   wrdh_pkg::sample_type     head;
   wrdh_pkg::sample_type     tail;
   wrdh_pkg::hold_status_type hold_status;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign commit         = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // chain steps on insert and on every scan cycle
   assign chain_ctl.insert = req_fire;
   assign chain_ctl.step   = req_fire || (state_ff == ST_SCAN);

   wrdh_chain #(
      .Depth (WINDOW_DEPTH)
   ) u_chain (
      .clock  (clock),
      .ctl    (chain_ctl),
      .sample (req_chan.sample),
      .head   (head),
      .tail   (tail)
   );

   wrdh_hold u_hold (
      .clock      (clock),
      .reset      (reset),
      .commit     (commit),
      .window_max (max_ff),
      .window_min (min_ff),
      .rising     (rise_ff),
      .threshold  (thresh_ff),
      .duration   (dur_ff),
      .status     (hold_status)
   );

   // tail cell holds a valid sample once the scan reaches the filled part
   assign scan_pos  = (FillW+1)'(scan_ff) + (FillW+1)'(fill_ff);
   assign in_window = (scan_pos >= (FillW+1)'(WINDOW_DEPTH));

   // sequencer: insert, rotate the ring once, then hand off the result
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      scan_in  = scan_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      rise_in  = rise_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (fill_ff != FillW'(WINDOW_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
               rise_in  = (fill_ff != '0) && (req_chan.sample > head);
               scan_in  = '0;
               max_in   = wrdh_pkg::SAMPLE_MIN;
               min_in   = wrdh_pkg::SAMPLE_MAX;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (in_window) begin
               if (tail > max_ff) begin
                  max_in = tail;
               end
               if (tail < min_ff) begin
                  min_in = tail;
               end
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == ScanW'(WINDOW_DEPTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   // scan datapath
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      max_ff  <= max_in;
      min_ff  <= min_in;
      rise_ff <= rise_in;
   end

   // configuration registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= wrdh_pkg::THRESH_RESET;
         dur_ff    <= wrdh_pkg::DURATION_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            wrdh_pkg::CSR_RISE_THRESHOLD: thresh_ff <= csr_chan.data[wrdh_pkg::THRESH_W-1:0];
            wrdh_pkg::CSR_MAX_DURATION:   dur_ff    <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // output register
   assign fill_wide = {5'd0, fill_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         out_fan_ff  <= hold_status.fan_on;
         out_hold_ff <= hold_status.hold_count;
         out_max_ff  <= max_ff;
         out_min_ff  <= min_ff;
         out_rise_ff <= rise_ff;
         out_fill_ff <= fill_wide[wrdh_pkg::FILL_OUT_W-1:0];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.fan_on     = out_fan_ff;
   assign rsp_chan.hold_count = out_hold_ff;
   assign rsp_chan.window_max = out_max_ff;
   assign rsp_chan.window_min = out_min_ff;
   assign rsp_chan.rising     = out_rise_ff;
   assign rsp_chan.fill_level = out_fill_ff;

   // a request always enters the scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN))
      else $error("request accepted but scan not started");

   // the window is never empty while a request is in flight
   a_fill_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (fill_ff != '0))
      else $error("request in flight with empty window");

   // fill count never passes the window depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillW'(WINDOW_DEPTH))
      else $error("fill count beyond window depth");

   // an active output always carries a nonzero hold count
   a_fan_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_fan_ff) |-> (out_hold_ff != '0))
      else $error("output on with zero hold count");

endmodule

`default_nettype wire

// ===== src/wrdh_cell.sv =====
// ---------------------------------------------------------------------------
// wrdh_cell: one window cell
// Holds one sample and takes its neighbor's sample when the chain steps.
// ---------------------------------------------------------------------------
`default_nettype none

module wrdh_cell (
   input  wire logic                 clock,
   input  wire logic                 step,
   input  wire wrdh_pkg::sample_type data_in,
   output wrdh_pkg::sample_type      data_out
);

   wrdh_pkg::sample_type data_ff;

   // sample storage, no reset: entries are qualified by the fill count
   always_ff @(posedge clock) begin
      if (step) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// ===== src/wrdh_chain.sv =====
// ---------------------------------------------------------------------------
// wrdh_chain: row of window cells
// Newest sample at the head; on a scan step the tail wraps to the head.
// ---------------------------------------------------------------------------
`default_nettype none

module wrdh_chain #(
   parameter int Depth = 16
) (
   input  wire logic                    clock,
   input  wire wrdh_pkg::chain_ctl_type ctl,
   input  wire wrdh_pkg::sample_type    sample,
   output wrdh_pkg::sample_type         head,
   output wrdh_pkg::sample_type         tail
);

   wrdh_pkg::sample_type link [Depth+1];

   // head input: new sample on insert, otherwise the tail closes the ring
   assign link[0] = ctl.insert ? sample : link[Depth];

   genvar g;
   generate
      for (g = 0; g < Depth; g++) begin : g_cell
         wrdh_cell u_cell (
            .clock    (clock),
            .step     (ctl.step),
            .data_in  (link[g]),
            .data_out (link[g+1])
         );
      end
   endgenerate

   assign head = link[1];
   assign tail = link[Depth];

endmodule

`default_nettype wire

// ===== src/wrdh_hold.sv =====
// ---------------------------------------------------------------------------
// wrdh_hold: trigger and hold counter
// Decides the output state from the window spread and the rise flag.
// ---------------------------------------------------------------------------
`default_nettype none

module wrdh_hold (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   commit,
   input  wire wrdh_pkg::sample_type   window_max,
   input  wire wrdh_pkg::sample_type   window_min,
   input  wire logic                   rising,
   input  wire wrdh_pkg::thresh_type   threshold,
   input  wire wrdh_pkg::duration_type duration,
   output wrdh_pkg::hold_status_type   status
);

   logic                   active_ff;
   logic                   active_in;
   wrdh_pkg::duration_type hold_ff;
   wrdh_pkg::duration_type hold_in;
   wrdh_pkg::sample_type   spread;
   logic                   trigger;
   logic                   set_active;
   logic [wrdh_pkg::DURATION_W:0] count_inc;

   // trigger on a wide spread while rising and not yet past the hold
   always_comb begin
      spread     = window_max - window_min;
      trigger    = (spread > threshold) && rising && (hold_ff < duration);
      set_active = active_ff | trigger;
      count_inc  = {1'b0, hold_ff};
      if (set_active || (hold_ff != '0)) begin
         count_inc = {1'b0, hold_ff} + 17'd1;
      end
      active_in = set_active;
      hold_in   = count_inc[wrdh_pkg::DURATION_W-1:0];
      if (count_inc > {1'b0, duration}) begin
         active_in = 1'b0;
         hold_in   = '0;
      end
   end

   // state update once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         hold_ff   <= '0;
      end else if (commit) begin
         active_ff <= active_in;
         hold_ff   <= hold_in;
      end
   end

   assign status.fan_on     = active_in;
   assign status.hold_count = hold_in;

endmodule

`default_nettype wire
